>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, reset disables checking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping (same-cycle) implication, checked at every clock edge out of reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/mctc_pkg.sv
// ----------------------------------------------------------------------------
// mctc_pkg
// types, codes and helpers for the circulant / toeplitz classifier
// ----------------------------------------------------------------------------
`default_nettype none

package mctc_pkg;

    localparam int MAX_DIM_DEF = 128;
    localparam int ELEM_W      = 32;
    localparam int DIM_W       = 8;
    localparam int TOL_W       = 31;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CLASS_W     = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS  = 2'd0,
        REG_NUM_COLS  = 2'd1,
        REG_TOLERANCE = 2'd2
    } cfg_reg_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_CIRCULANT = 2'd0,
        CLASS_TOEPLITZ  = 2'd1,
        CLASS_NEITHER   = 2'd2
    } matrix_class_t;

    // absolute difference above tolerance
    function automatic logic differs(
        input logic [ELEM_W-1:0] a,
        input logic [ELEM_W-1:0] b,
        input logic [TOL_W-1:0]  tol
    );
        logic [ELEM_W:0] diff;
        logic [ELEM_W:0] mag;
        diff = {a[ELEM_W-1], a} - {b[ELEM_W-1], b};
        mag  = diff[ELEM_W] ? (~diff + (ELEM_W+1)'(1)) : diff;
        return mag > {2'b00, tol};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mctc_ram.sv
// ----------------------------------------------------------------------------
// mctc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mctc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/matrix_circulant_toeplitz_check_core.sv
// ----------------------------------------------------------------------------
// matrix_circulant_toeplitz_check_core
// classifies a streamed matrix as circulant, toeplitz or neither
// ----------------------------------------------------------------------------
// Takes one Q16.16 element per cycle in row-major order, with no gaps needed
// between elements or between matrices. Each element is taken into a single
// check stage: the first row and the previous row sit in two RAMs whose
// registered reads are issued as the element is accepted. The toeplitz
// compare is made on accept, the circulant one in the following cycle. The
// class of a matrix is loaded into the output register when its last element
// leaves the check stage. The element input stalls only while the last element
// of a matrix waits in the check stage behind a class that has not yet been
// taken. Writing num_rows or num_cols abandons the matrix in progress;
// tolerance may be changed between matrices without restarting anything.
`default_nettype none
`include "assert_macros.svh"

module matrix_circulant_toeplitz_check_core
    import mctc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  elem_valid,
    output logic                       elem_stall,
    input  wire logic [ELEM_W-1:0]     element,
    output logic                       class_valid,
    input  wire logic                  class_stall,
    output logic [CLASS_W-1:0]         matrix_class
);

    localparam int IDX_W = $clog2(MAX_DIM);

    logic [DIM_W-1:0]   num_rows_reg;
    logic [DIM_W-1:0]   num_cols_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [IDX_W-1:0]   rot_reg, rot_next;
    logic               circ_failed_reg, circ_failed_next;
    logic               toep_failed_reg, toep_failed_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [ELEM_W-1:0]  s1_elem_reg;
    logic               s1_circ_chk_reg;
    logic               s1_toep_fail_reg;
    logic               s1_last_reg;
    logic               class_valid_reg, class_valid_next;
    logic [CLASS_W-1:0] class_reg;

    logic [IDX_W-1:0]   rows_m1;
    logic [IDX_W-1:0]   cols_m1;
    logic [31:0]        rows_tmp;
    logic [31:0]        cols_tmp;
    logic               accept;
    logic               s1_adv;
    logic               out_load;
    logic               dim_write;
    logic               last_col;
    logic               last_row;
    logic [IDX_W-1:0]   rot_inc;
    logic [ELEM_W-1:0]  first_rd;
    logic [ELEM_W-1:0]  prev_rd;
    logic               circ_fail_now;
    logic               toep_fail_in;
    matrix_class_t      class_next;

    // effective dimensions minus one, zero acts as one, clipped to MAX_DIM
    assign rows_tmp = 32'(num_rows_reg) - 32'd1;
    assign cols_tmp = 32'(num_cols_reg) - 32'd1;

    always_comb
    begin
        priority if (num_rows_reg == '0)
            rows_m1 = '0;
        else if (32'(num_rows_reg) > 32'(MAX_DIM))
            rows_m1 = IDX_W'(MAX_DIM - 1);
        else
            rows_m1 = rows_tmp[IDX_W-1:0];

        priority if (num_cols_reg == '0)
            cols_m1 = '0;
        else if (32'(num_cols_reg) > 32'(MAX_DIM))
            cols_m1 = IDX_W'(MAX_DIM - 1);
        else
            cols_m1 = cols_tmp[IDX_W-1:0];
    end

    // handshake
    assign out_load   = s1_valid_reg && s1_last_reg && s1_adv;
    assign s1_adv     = s1_valid_reg && (!s1_last_reg || !class_valid_reg || !class_stall);
    assign elem_stall = s1_valid_reg && !s1_adv;
    assign accept     = elem_valid && !elem_stall;
    assign dim_write  = cfg_wr_en && ((cfg_reg_t'(cfg_index) == REG_NUM_ROWS) ||
                                      (cfg_reg_t'(cfg_index) == REG_NUM_COLS));

    // row stores
    mctc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_DIM)
    ) u_first_row (
        .clk     (clk),
        .wr_en   (accept && (row_reg == '0)),
        .wr_addr (col_reg),
        .wr_data (element),
        .rd_en   (accept),
        .rd_addr (rot_reg),
        .rd_data (first_rd)
    );

    mctc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_DIM)
    ) u_prev_row (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (element),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (prev_rd)
    );

    // prev_rd still holds the old value one row up, one column left
    assign toep_fail_in  = (row_reg != '0) && (col_reg != '0) &&
                           differs(element, prev_rd, tolerance_reg);
    assign circ_fail_now = s1_circ_chk_reg && differs(s1_elem_reg, first_rd, tolerance_reg);

    // position tracking
    assign last_col = (col_reg == cols_m1);
    assign last_row = (row_reg == rows_m1);
    assign rot_inc  = (rot_reg == cols_m1) ? '0 : rot_reg + IDX_W'(1);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        rot_next = rot_reg;
        if (dim_write)
        begin
            row_next = '0;
            col_next = '0;
            rot_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                // rotate right by one for the next row
                rot_next = (rot_inc == '0) ? cols_m1 : rot_inc - IDX_W'(1);
                col_next = '0;
                row_next = last_row ? '0 : row_reg + IDX_W'(1);
                if (last_row)
                begin
                    rot_next = '0;
                end
            end
            else
            begin
                rot_next = rot_inc;
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    // flags and class
    always_comb
    begin
        circ_failed_next = circ_failed_reg;
        toep_failed_next = toep_failed_reg;
        class_next       = CLASS_NEITHER;
        if (!(circ_failed_reg || circ_fail_now))
            class_next = CLASS_CIRCULANT;
        else if (!(toep_failed_reg || s1_toep_fail_reg))
            class_next = CLASS_TOEPLITZ;
        if (dim_write)
        begin
            circ_failed_next = 1'b0;
            toep_failed_next = 1'b0;
        end
        else if (s1_adv)
        begin
            circ_failed_next = s1_last_reg ? 1'b0 : (circ_failed_reg || circ_fail_now);
            toep_failed_next = s1_last_reg ? 1'b0 : (toep_failed_reg || s1_toep_fail_reg);
        end
    end

    assign s1_valid_next    = accept || (s1_valid_reg && !s1_adv);
    assign class_valid_next = out_load || (class_valid_reg && class_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg    <= DIM_RESET;
            num_cols_reg    <= DIM_RESET;
            tolerance_reg   <= TOL_RESET;
            row_reg         <= '0;
            col_reg         <= '0;
            rot_reg         <= '0;
            circ_failed_reg <= 1'b0;
            toep_failed_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            class_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_NUM_ROWS:  num_rows_reg  <= cfg_data[DIM_W-1:0];
                    REG_NUM_COLS:  num_cols_reg  <= cfg_data[DIM_W-1:0];
                    REG_TOLERANCE: tolerance_reg <= cfg_data[TOL_W-1:0];
                    default:       ;
                endcase
            end
            row_reg         <= row_next;
            col_reg         <= col_next;
            rot_reg         <= rot_next;
            circ_failed_reg <= circ_failed_next;
            toep_failed_reg <= toep_failed_next;
            s1_valid_reg    <= s1_valid_next;
            class_valid_reg <= class_valid_next;
        end
    end

    // check stage and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_elem_reg      <= element;
            s1_circ_chk_reg  <= (row_reg != '0);
            s1_toep_fail_reg <= toep_fail_in;
            s1_last_reg      <= last_col && last_row;
        end
        if (out_load)
        begin
            class_reg <= class_next;
        end
    end

    assign class_valid  = class_valid_reg;
    assign matrix_class = class_reg;

    `ASSERT_IMPL(a_stall_needs_item, elem_stall, s1_valid_reg)
    `ASSERT_NEXT(a_result_loaded, out_load, class_valid)
    `ASSERT_NEXT(a_result_drained, class_valid && !class_stall && !out_load, !class_valid)
    `ASSERT_IMPL(a_col_in_range, 1'b1, (col_reg <= cols_m1) && (rot_reg <= cols_m1))
    `ASSERT_IMPL(a_row_in_range, 1'b1, row_reg <= rows_m1)
    `ASSERT_IMPL(a_class_code, class_valid, matrix_class <= CLASS_NEITHER)

endmodule

`default_nettype wire
